### hdl/ipcr_pkg.sv
// Package for the IR pulse capture and replay block.
// Holds the shared codes, default sizes and the controller/datapath interface types.
// No dependencies.
package ipcr_pkg;

  localparam int SAMPLES_DEF = 128;
  localparam int SLOTS_DEF = 3;

  localparam logic [14:0] TIMEOUT_RST = 15'd4096;
  localparam logic [15:0] LOW_SAT = 16'h7FFF;
  localparam logic [15:0] HIGH_FLAG = 16'h8000;
  localparam logic [15:0] END_WORD = 16'hFFFF;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_LEARN = 2'd1;
  localparam logic [1:0] FUNC_REPLAY = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LEARN,
    MODE_REPLAY
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic check;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fetch_req;
    logic idx_end;
    logic word_end;
    logic word_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

### hdl/ipcr_ctrl.sv
// Controller state machine for the IR pulse capture and replay block.
// Sequences capture, execution, word fetches and the result transfer.
// Depends on ipcr_pkg.
module ipcr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ipcr_pkg::ctrl_sts_t  sts,
  output ipcr_pkg::ctrl_cmd_t  cmd
);

  ipcr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipcr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ipcr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = ipcr_pkg::ST_EXEC;
        end
      end
      ipcr_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = sts.fetch_req ? ipcr_pkg::ST_READ : ipcr_pkg::ST_DONE;
      end
      ipcr_pkg::ST_READ: begin
        cmd.read = 1'b1;
        state_nxt = sts.idx_end ? ipcr_pkg::ST_DONE : ipcr_pkg::ST_CHECK;
      end
      ipcr_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.word_end || !sts.word_zero) begin
          state_nxt = ipcr_pkg::ST_DONE;
        end else begin
          state_nxt = ipcr_pkg::ST_READ;
        end
      end
      ipcr_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = ipcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipcr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/ipcr_dp.sv
// Datapath for the IR pulse capture and replay block: pulse store, counters,
// per-slot fill counts, timeout register and the result register.
// Depends on ipcr_pkg.
module ipcr_dp #(
  parameter int SAMPLES = ipcr_pkg::SAMPLES_DEF,
  parameter int SLOTS = ipcr_pkg::SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_func,
  input  logic [1:0]           in_slot,
  input  logic                 in_level,
  input  logic                 cfg_wr_en,
  input  logic [14:0]          cfg_wr_data,
  input  ipcr_pkg::ctrl_cmd_t  cmd,
  output ipcr_pkg::ctrl_sts_t  sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [15:0]          out_data
);

  localparam int IDX_W = $clog2(SAMPLES + 1);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH = SLOTS * SAMPLES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(SAMPLES);

  logic [1:0]        func_r, func_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic              level_r, level_nxt;
  logic              carrier_r, carrier_nxt;
  logic              done_r, done_nxt;
  ipcr_pkg::mode_t   mode_r, mode_nxt;
  logic [SLOT_W-1:0] slot_act_r, slot_act_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic              phase_r, phase_nxt;
  logic              await_r, await_nxt;
  logic [14:0]       timeout_r;
  logic [IDX_W-1:0]  hwm_r [SLOTS];
  logic [IDX_W-1:0]  hwm_nxt;
  logic              hwm_we;
  logic [15:0]       rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_carrier_r;
  logic              out_busy_r;
  logic              out_done_r;
  logic [7:0]        out_index_r;

  logic [15:0]       mem [DEPTH];
  logic [ADDR_W-1:0] addr;
  logic              mem_we;
  logic [15:0]       mem_wdata;
  logic              rd_en;

  logic [IDX_W-1:0]  hwm_cur;
  logic [IDX_W-1:0]  idx_inc;
  logic              idx_full;
  logic              idx_end;
  logic [15:0]       tick_inc;
  logic [15:0]       tick_dec;
  logic [15:0]       word_sel;
  logic              slot_ok;
  logic              fetch_req;

  assign hwm_cur = hwm_r[slot_act_r];
  assign idx_inc = idx_r + 1'b1;
  assign idx_full = (idx_inc >= IDX_END);
  assign idx_end = (idx_r >= IDX_END);
  assign tick_inc = tick_r + 16'd1;
  assign tick_dec = (tick_r != 16'd0) ? tick_r - 16'd1 : 16'd0;
  assign word_sel = (idx_r >= hwm_cur) ? ipcr_pkg::END_WORD : rd_data_r;
  assign slot_ok = (int'(slot_r) < SLOTS);
  assign addr = ADDR_W'(slot_act_r) * ADDR_W'(SAMPLES) + ADDR_W'(idx_r);
  assign rd_en = cmd.read && !idx_end;

  always_comb begin
    func_nxt = func_r;
    slot_nxt = slot_r;
    level_nxt = level_r;
    carrier_nxt = carrier_r;
    done_nxt = done_r;
    mode_nxt = mode_r;
    slot_act_nxt = slot_act_r;
    idx_nxt = idx_r;
    tick_nxt = tick_r;
    phase_nxt = phase_r;
    await_nxt = await_r;
    hwm_nxt = hwm_cur;
    hwm_we = 1'b0;
    mem_we = 1'b0;
    mem_wdata = tick_r & ipcr_pkg::LOW_SAT;
    fetch_req = 1'b0;

    if (cmd.capture) begin
      func_nxt = in_func;
      slot_nxt = in_slot;
      level_nxt = in_level;
      carrier_nxt = 1'b0;
      done_nxt = 1'b0;
    end

    if (cmd.exec) begin
      if ((func_r == ipcr_pkg::FUNC_LEARN || func_r == ipcr_pkg::FUNC_REPLAY) && slot_ok) begin
        slot_act_nxt = SLOT_W'(slot_r);
        idx_nxt = '0;
        tick_nxt = 16'd0;
        phase_nxt = 1'b0;
        await_nxt = 1'b0;
        if (func_r == ipcr_pkg::FUNC_LEARN) begin
          mode_nxt = ipcr_pkg::MODE_LEARN;
          await_nxt = 1'b1;
        end else begin
          mode_nxt = ipcr_pkg::MODE_REPLAY;
          fetch_req = 1'b1;
        end
      end else if (func_r == ipcr_pkg::FUNC_TICK && mode_r == ipcr_pkg::MODE_LEARN) begin
        if (await_r) begin
          if (!level_r) begin
            await_nxt = 1'b0;
            phase_nxt = 1'b0;
            tick_nxt = 16'd1;
          end
        end else if (!phase_r) begin
          if (!level_r) begin
            if (tick_r < ipcr_pkg::LOW_SAT) begin
              tick_nxt = tick_inc;
            end
          end else begin
            mem_we = 1'b1;
            mem_wdata = tick_r & ipcr_pkg::LOW_SAT;
            hwm_we = 1'b1;
            hwm_nxt = (idx_inc > hwm_cur) ? idx_inc : hwm_cur;
            idx_nxt = idx_inc;
            if (idx_full) begin
              mode_nxt = ipcr_pkg::MODE_IDLE;
              done_nxt = 1'b1;
            end else begin
              phase_nxt = 1'b1;
              tick_nxt = 16'd1;
              if (timeout_r == 15'd0) begin
                hwm_nxt = idx_inc;
                idx_nxt = IDX_END;
                mode_nxt = ipcr_pkg::MODE_IDLE;
                done_nxt = 1'b1;
              end
            end
          end
        end else begin
          if (level_r) begin
            tick_nxt = tick_inc;
            if (tick_inc > {1'b0, timeout_r}) begin
              hwm_we = 1'b1;
              hwm_nxt = idx_r;
              idx_nxt = IDX_END;
              mode_nxt = ipcr_pkg::MODE_IDLE;
              done_nxt = 1'b1;
            end
          end else begin
            mem_we = 1'b1;
            mem_wdata = ipcr_pkg::HIGH_FLAG | (tick_r & ipcr_pkg::LOW_SAT);
            hwm_we = 1'b1;
            hwm_nxt = (idx_inc > hwm_cur) ? idx_inc : hwm_cur;
            idx_nxt = idx_inc;
            if (idx_full) begin
              mode_nxt = ipcr_pkg::MODE_IDLE;
              done_nxt = 1'b1;
            end else begin
              phase_nxt = 1'b0;
              tick_nxt = 16'd1;
            end
          end
        end
      end else if (func_r == ipcr_pkg::FUNC_TICK && mode_r == ipcr_pkg::MODE_REPLAY) begin
        carrier_nxt = !phase_r;
        tick_nxt = tick_dec;
        if (tick_dec == 16'd0) begin
          idx_nxt = idx_inc;
          fetch_req = 1'b1;
        end
      end
    end

    if (cmd.read && idx_end) begin
      mode_nxt = ipcr_pkg::MODE_IDLE;
      done_nxt = 1'b1;
    end

    if (cmd.check) begin
      if (word_sel == ipcr_pkg::END_WORD) begin
        mode_nxt = ipcr_pkg::MODE_IDLE;
        done_nxt = 1'b1;
      end else if (word_sel[14:0] != 15'd0) begin
        tick_nxt = {1'b0, word_sel[14:0]};
        phase_nxt = word_sel[15];
      end else begin
        idx_nxt = idx_inc;
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    sts.fetch_req = fetch_req;
    sts.idx_end = idx_end;
    sts.word_end = (word_sel == ipcr_pkg::END_WORD);
    sts.word_zero = (word_sel[14:0] == 15'd0);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ipcr_pkg::MODE_IDLE;
      slot_act_r <= '0;
      idx_r <= '0;
      tick_r <= 16'd0;
      phase_r <= 1'b0;
      await_r <= 1'b0;
      timeout_r <= ipcr_pkg::TIMEOUT_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        hwm_r[i] <= '0;
      end
    end else begin
      mode_r <= mode_nxt;
      slot_act_r <= slot_act_nxt;
      idx_r <= idx_nxt;
      tick_r <= tick_nxt;
      phase_r <= phase_nxt;
      await_r <= await_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (hwm_we) begin
        hwm_r[slot_act_r] <= hwm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    slot_r <= slot_nxt;
    level_r <= level_nxt;
    carrier_r <= carrier_nxt;
    done_r <= done_nxt;
    if (cmd.load_out) begin
      out_carrier_r <= carrier_r;
      out_busy_r <= (mode_r != ipcr_pkg::MODE_IDLE);
      out_done_r <= done_r;
      out_index_r <= 8'(idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = {5'b0, out_index_r, out_done_r, out_busy_r, out_carrier_r};

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_END)
    else $error("Word index is past the end of the slot.");

  a_learn_idx: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == ipcr_pkg::MODE_LEARN |-> idx_r < IDX_END)
    else $error("Learning continues in a full slot.");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_cur <= IDX_END)
    else $error("Slot fill count is past the end of the slot.");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r)
    else $error("A finishing result still reports busy.");
`endif

endmodule

### hdl/ir_pulse_capture_replay.sv
// Top level of the IR pulse capture and replay block.
// Joins the controller (ipcr_ctrl) and the datapath (ipcr_dp); depends on ipcr_pkg.
//
// Channel   Direction  Handshake                 Payload
// in_       slave      in_tvalid / in_tready     in_tuser: func; in_tdata: slot, ir_level
// out_      master     out_tvalid / out_tready   out_tdata: carrier_on, busy_res, done_res,
//                                                entry_index
// cfg_      write      cfg_wr_en                 cfg_wr_data: high_timeout
//
// A tick or start command is captured, executed and its result handed to the output register;
// each word fetched during replay adds one store read and one check, and a walk that reaches
// the slot end adds one more read.
// Reset is synchronous and active low; unwritten store words read as 0xFFFF through
// per-slot fill counts, so no clearing pass follows reset.
// A stalled result waits in the output register while the next item is being worked on.
module ir_pulse_capture_replay #(
  parameter int SAMPLES = ipcr_pkg::SAMPLES_DEF,
  parameter int SLOTS = ipcr_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [1:0] slot, [2] ir_level, [7:3] zero
  input  logic [1:0]  in_tuser,    // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [0] carrier_on, [1] busy_res, [2] done_res,
                                   // [10:3] entry_index, [15:11] zero
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);

  ipcr_pkg::ctrl_cmd_t cmd;
  ipcr_pkg::ctrl_sts_t sts;

  ipcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipcr_dp #(
    .SAMPLES (SAMPLES),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_func     (in_tuser),
    .in_slot     (in_tdata[1:0]),
    .in_level    (in_tdata[2]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_data    (out_tdata)
  );

endmodule

### tb/sv/tb_ir_pulse_capture_replay.sv
// Self-checking testbench for ir_pulse_capture_replay: stream driver, monitor
// and status predictor, learning and replaying patterns under several timeouts.
// Depends on ipcr_pkg and the ir_pulse_capture_replay RTL.
module tb_ir_pulse_capture_replay;

  localparam int NSLOT = ipcr_pkg::SLOTS_DEF;
  localparam int NWORD = ipcr_pkg::SAMPLES_DEF;
  localparam logic [1:0] FUNC_RSVD = 2'd3;
  localparam logic [1:0] SLOT_BAD = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] slot;
    logic       level;
  } ir_item_t;

  typedef struct packed {
    logic       carrier;
    logic       busy;
    logic       done;
    logic [7:0] index;
  } ir_status_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_wr_en;
  logic [14:0] cfg_wr_data;

  ir_item_t   item_queue[$];
  ir_status_t status_queue[$];

  logic [15:0]     shadow_mem [NSLOT*NWORD];
  ipcr_pkg::mode_t cur_mode;
  int unsigned     cur_slot;
  int unsigned     cur_word;
  logic [15:0]     cur_ticks;
  logic            in_high;
  logic            wait_low;
  logic [14:0]     hi_limit;

  int errors;
  int sent_items;
  int checked;
  int finished_ops;
  int settings_used;
  bit idle_on;
  bit in_took;
  int in_gap;
  int out_gap;

  ir_pulse_capture_replay dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic void reset_shadow();
    int i;
    for (i = 0; i < NSLOT * NWORD; i++) shadow_mem[i] = ipcr_pkg::END_WORD;
    cur_mode = ipcr_pkg::MODE_IDLE;
    cur_slot = 0;
    cur_word = 0;
    cur_ticks = '0;
    in_high = 1'b0;
    wait_low = 1'b0;
    hi_limit = ipcr_pkg::TIMEOUT_RST;
  endfunction

  function automatic bit store_word(logic [15:0] value);
    if (cur_word < NWORD) shadow_mem[cur_slot * NWORD + cur_word] = value;
    cur_word++;
    return cur_word >= NWORD;
  endfunction

  function automatic void fill_rest();
    while (cur_word < NWORD) begin
      shadow_mem[cur_slot * NWORD + cur_word] = ipcr_pkg::END_WORD;
      cur_word++;
    end
  endfunction

  // Loads the next word with a nonzero length; returns 1 when replay is over.
  function automatic bit load_next();
    logic [15:0] w;
    while (cur_word < NWORD) begin
      w = shadow_mem[cur_slot * NWORD + cur_word];
      if (w == ipcr_pkg::END_WORD) return 1'b1;
      if (w[14:0] != 15'd0) begin
        cur_ticks = {1'b0, w[14:0]};
        in_high = w[15];
        return 1'b0;
      end
      cur_word++;
    end
    return 1'b1;
  endfunction

  function automatic ir_status_t predict_status(logic [1:0] fn, logic [1:0] sl, logic lv);
    ir_status_t r;
    bit fin;
    r = '0;
    fin = 1'b0;
    if ((fn == ipcr_pkg::FUNC_LEARN || fn == ipcr_pkg::FUNC_REPLAY) && int'(sl) < NSLOT) begin
      cur_slot = int'(sl);
      cur_word = 0;
      cur_ticks = '0;
      in_high = 1'b0;
      wait_low = 1'b0;
      if (fn == ipcr_pkg::FUNC_LEARN) begin
        cur_mode = ipcr_pkg::MODE_LEARN;
        wait_low = 1'b1;
      end else begin
        cur_mode = ipcr_pkg::MODE_REPLAY;
        fin = load_next();
      end
    end else if (fn == ipcr_pkg::FUNC_TICK && cur_mode == ipcr_pkg::MODE_LEARN) begin
      if (wait_low) begin
        if (!lv) begin
          wait_low = 1'b0;
          in_high = 1'b0;
          cur_ticks = 16'd1;
        end
      end else if (!in_high) begin
        if (!lv) begin
          if (cur_ticks < ipcr_pkg::LOW_SAT) cur_ticks++;
        end else begin
          fin = store_word(cur_ticks & ipcr_pkg::LOW_SAT);
          if (!fin) begin
            in_high = 1'b1;
            cur_ticks = 16'd1;
            if (cur_ticks > {1'b0, hi_limit}) begin
              fill_rest();
              fin = 1'b1;
            end
          end
        end
      end else begin
        if (lv) begin
          cur_ticks++;
          if (cur_ticks > {1'b0, hi_limit}) begin
            fill_rest();
            fin = 1'b1;
          end
        end else begin
          fin = store_word(ipcr_pkg::HIGH_FLAG | (cur_ticks & ipcr_pkg::LOW_SAT));
          if (!fin) begin
            in_high = 1'b0;
            cur_ticks = 16'd1;
          end
        end
      end
    end else if (fn == ipcr_pkg::FUNC_TICK && cur_mode == ipcr_pkg::MODE_REPLAY) begin
      r.carrier = !in_high;
      if (cur_ticks > 16'd0) cur_ticks--;
      if (cur_ticks == 16'd0) begin
        cur_word++;
        fin = load_next();
      end
    end
    if (fin) begin
      cur_mode = ipcr_pkg::MODE_IDLE;
      r.done = 1'b1;
    end
    r.busy = (cur_mode != ipcr_pkg::MODE_IDLE);
    r.index = cur_word[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    $display("Mismatch at result %0d: %s is %0d, expected %0d", checked, field, got, want);
  endtask

  task automatic send(logic [1:0] fn, logic [1:0] sl, logic lv);
    ir_item_t it;
    it.func = fn;
    it.slot = sl;
    it.level = lv;
    item_queue.push_back(it);
    sent_items++;
  endtask

  task automatic send_noise();
    send(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_inputs_taken();
    while (item_queue.size() != 0 || in_tvalid) @(posedge clk);
  endtask

  task automatic write_timeout(logic [14:0] value);
    while (item_queue.size() != 0 || in_tvalid || status_queue.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    hi_limit = value;
    settings_used++;
  endtask

  // Low and high phases alternate, starting low; some runs fill the whole slot
  // with short phases.
  task automatic learn_run(logic [1:0] sl);
    int words;
    int n;
    int k;
    int hmax;
    bit fill;
    fill = ($urandom_range(0, 4) == 0);
    words = fill ? $urandom_range(126, 135) : $urandom_range(1, 20);
    hmax = (hi_limit < 15'd9) ? int'(hi_limit) : 9;
    send(ipcr_pkg::FUNC_LEARN, sl, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3)) send(ipcr_pkg::FUNC_TICK, 2'($urandom_range(0, 3)), 1'b1);
    for (k = 0; k < words; k++) begin
      if (fill) begin
        n = (hmax < 2) ? 1 : $urandom_range(1, 2);
      end else if (k % 2 == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
      end else begin
        n = $urandom_range(1, hmax);
      end
      repeat (n) begin
        send(ipcr_pkg::FUNC_TICK, 2'($urandom_range(0, 3)), (k % 2 == 0) ? 1'b0 : 1'b1);
      end
      if ($urandom_range(0, 11) == 0) send_noise();
    end
    if (hi_limit <= 15'd64 && $urandom_range(0, 2) != 0) begin
      repeat (int'(hi_limit) + 1 + $urandom_range(0, 2)) begin
        send(ipcr_pkg::FUNC_TICK, 2'($urandom_range(0, 3)), 1'b1);
      end
    end
  endtask

  // The tick count comes from the words already learned into the slot.
  task automatic replay_run(logic [1:0] sl);
    int need;
    int i;
    logic [15:0] w;
    wait_inputs_taken();
    need = 0;
    for (i = 0; i < NWORD; i++) begin
      w = shadow_mem[int'(sl) * NWORD + i];
      if (w == ipcr_pkg::END_WORD) break;
      need += int'(w[14:0]);
    end
    send(ipcr_pkg::FUNC_REPLAY, sl, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 5) == 0) need = int'($urandom_range(0, need));
    else need = need + $urandom_range(0, 2);
    for (i = 0; i < need; i++) begin
      if ($urandom_range(0, 40) == 0) begin
        send(FUNC_RSVD, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
      send(ipcr_pkg::FUNC_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin : driver
    ir_item_t nxt;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (in_gap == 0 && idle_on && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 13);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (item_queue.size() != 0) begin
        nxt = item_queue.pop_front();
        in_tuser <= nxt.func;
        in_tdata <= {5'd0, nxt.level, nxt.slot};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    ir_status_t want;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (status_queue.size() == 0) begin
          report_mismatch("unexpected result word", int'(out_tdata), 0);
        end else begin
          want = status_queue.pop_front();
          if (out_tdata[0] !== want.carrier) begin
            report_mismatch("carrier_on", int'(out_tdata[0]), int'(want.carrier));
          end
          if (out_tdata[1] !== want.busy) begin
            report_mismatch("busy_res", int'(out_tdata[1]), int'(want.busy));
          end
          if (out_tdata[2] !== want.done) begin
            report_mismatch("done_res", int'(out_tdata[2]), int'(want.done));
          end
          if (out_tdata[10:3] !== want.index) begin
            report_mismatch("entry_index", int'(out_tdata[10:3]), int'(want.index));
          end
          if (want.done) finished_ops++;
          checked++;
        end
      end
      in_took = in_tvalid && in_tready;
      if (in_took) status_queue.push_back(predict_status(in_tuser, in_tdata[1:0], in_tdata[2]));
    end
  end

  initial begin
    #50000000;
    $display("Timed out with %0d results still expected", status_queue.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [14:0] phase_limit [6];
    int p;
    int target;
    int pick;
    errors = 0;
    sent_items = 0;
    checked = 0;
    finished_ops = 0;
    settings_used = 0;
    idle_on = 1'b1;
    in_took = 1'b0;
    in_gap = 0;
    out_gap = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    reset_shadow();
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reserved code, idle tick, erased slot, bad slots, a short learn restarted, its replay.
    send(FUNC_RSVD, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_REPLAY, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_LEARN, SLOT_BAD, 1'b0);
    send(ipcr_pkg::FUNC_REPLAY, SLOT_BAD, 1'b1);
    send(ipcr_pkg::FUNC_LEARN, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd3, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_TICK, 2'd1, 1'b0);
    send(ipcr_pkg::FUNC_TICK, 2'd2, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_LEARN, 2'd1, 1'b0);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_REPLAY, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    send(FUNC_RSVD, 2'd2, 1'b0);
    repeat (4) send(ipcr_pkg::FUNC_TICK, 2'd1, 1'b1);

    // Shortest timeout: a high phase that times out, then one long low phase and its replay.
    write_timeout(15'd1);
    send(ipcr_pkg::FUNC_LEARN, 2'd1, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    send(ipcr_pkg::FUNC_LEARN, 2'd2, 1'b0);
    repeat (40) send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    repeat (2) send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b0);
    repeat (2) send(ipcr_pkg::FUNC_TICK, 2'd0, 1'b1);
    replay_run(2'd2);

    phase_limit = '{15'd1, 15'd32767, 15'($urandom_range(2, 12)), 15'($urandom_range(13, 60)),
                    ipcr_pkg::TIMEOUT_RST, 15'($urandom_range(1, 30))};
    for (p = 0; p < 6; p++) begin
      if (p > 0) write_timeout(phase_limit[p]);
      idle_on = (p != 5);
      target = sent_items + 220;
      while (sent_items < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) learn_run(2'($urandom_range(0, 2)));
        else if (pick < 16) replay_run(2'($urandom_range(0, 2)));
        else repeat ($urandom_range(1, 5)) send_noise();
      end
    end

    while (item_queue.size() != 0 || in_tvalid || status_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d items under %0d timeout settings; %0d results checked, %0d runs finished.",
             sent_items, settings_used + 1, checked, finished_ops);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hdl/ipcr_pkg.sv
hdl/ipcr_ctrl.sv
hdl/ipcr_dp.sv
hdl/ir_pulse_capture_replay.sv
tb/sv/tb_ir_pulse_capture_replay.sv
